/* rtl/ffa_pkg.sv */
// shared constants for the first-fit free-list allocator
package ffa_pkg;
	localparam int ARENA_WORDS_DEF = 4096;
	localparam int ADDR_BITS = 12;
	localparam int SIZE_BITS = 12;
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE = 1'b1;
	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;
	localparam int MIN_REMAINDER_WORDS = 2;
endpackage

/* rtl/ffa_alu.sv */
// shared adder/subtractor used by the allocator sequencer
module ffa_alu #(
	parameter int DW = 16
) (
	input  logic [DW-1:0] x,
	input  logic [DW-1:0] y,
	input  logic          sub,
	output logic [DW-1:0] res,
	output logic          borrow
);
	logic [DW:0] full;

	always_comb begin
		if (sub) begin
			full = {1'b0, x} - {1'b0, y};
		end else begin
			full = {1'b0, x} + {1'b0, y};
		end
	end

	assign res = full[DW-1:0];
	assign borrow = sub & full[DW];
endmodule

/* rtl/ffa_mem.sv */
// header store with one write port and one registered read port
module ffa_mem #(
	parameter int ARENA_WORDS = ffa_pkg::ARENA_WORDS_DEF,
	parameter int DW = 16,
	parameter int SW = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [DW-1:0] waddr,
	input  logic [SW-1:0] wdata,
	input  logic [DW-1:0] raddr,
	output logic [SW-1:0] rdata
);
	localparam int AW = $clog2(ARENA_WORDS);

	logic [SW-1:0] mem_q [ARENA_WORDS];
	logic [SW-1:0] raw_q;
	logic          init0_q, init1_q;
	logic          rin_q, r0_q, r1_q;
	logic          w_in, r_in;

	assign w_in = waddr < DW'(ARENA_WORDS);
	assign r_in = raddr < DW'(ARENA_WORDS);

	always_ff @(posedge clk) begin
		if (we && w_in) begin
			mem_q[waddr[AW-1:0]] <= wdata;
		end
		raw_q <= mem_q[raddr[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init0_q <= 1'b1;
			init1_q <= 1'b1;
			rin_q <= 1'b0;
			r0_q <= 1'b0;
			r1_q <= 1'b0;
		end else begin
			if (we && waddr == DW'(0)) begin
				init0_q <= 1'b0;
			end
			if (we && waddr == DW'(1)) begin
				init1_q <= 1'b0;
			end
			rin_q <= r_in;
			r0_q <= init0_q && raddr == DW'(0);
			r1_q <= init1_q && raddr == DW'(1);
		end
	end

	always_comb begin
		if (!rin_q || r1_q) begin
			rdata = '0;
		end else if (r0_q) begin
			rdata = SW'(ARENA_WORDS);
		end else begin
			rdata = raw_q;
		end
	end
endmodule

/* rtl/first_fit_free_list_allocator.sv */
// First-fit free-list allocator over an arena of ARENA_WORDS header words. One request at a
// time: an alloc walks the address-ordered free list through the header store, which has one
// write port and one registered read port. It reads the size and link of each visited free
// block, then splits the chosen block and relinks. A free reads its own block's size before
// its walk, steps past the free blocks below it, and then merges with its neighbours and
// relinks. The walk length bounds the rate. A new request is taken while the last result
// still waits on the rsp side.
module first_fit_free_list_allocator #(
	parameter int ARENA_WORDS = ffa_pkg::ARENA_WORDS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic                          operation,
	input  logic [ffa_pkg::SIZE_BITS-1:0] size_words,
	input  logic [ffa_pkg::ADDR_BITS-1:0] user_address,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [ffa_pkg::ADDR_BITS-1:0] alloc_address,
	output logic                          status
);
	localparam int AW = $clog2(ARENA_WORDS);
	localparam int SW = $clog2(ARENA_WORDS + 1);
	localparam int DW = (AW + 3 > 14) ? AW + 3 : 14;
	localparam int CW = $clog2(ARENA_WORDS + 1);

	localparam logic [5:0] IDLE = 6'd0,  A_IT = 6'd1,  A_SZ = 6'd2,  A_CK = 6'd3;
	localparam logic [5:0] A_W1 = 6'd4,  A_W2 = 6'd5,  A_W3 = 6'd6,  A_LK = 6'd7;
	localparam logic [5:0] F_0 = 6'd8,   F_EMP = 6'd9, F_1 = 6'd10,  F_2 = 6'd11;
	localparam logic [5:0] F_H1 = 6'd12, F_HN = 6'd13, F_H2 = 6'd14, F_H3 = 6'd15;
	localparam logic [5:0] F_H4 = 6'd16, F_H5 = 6'd17, F_IT = 6'd18, F_W1 = 6'd19;
	localparam logic [5:0] F_T1 = 6'd20, F_T2 = 6'd21, F_T3 = 6'd22, F_T4 = 6'd23;
	localparam logic [5:0] F_M1 = 6'd24, F_M2 = 6'd25, F_M3 = 6'd26, F_B1 = 6'd27;
	localparam logic [5:0] F_B2 = 6'd28, F_B3 = 6'd29, F_B4 = 6'd30, F_B5 = 6'd31;
	localparam logic [5:0] F_N1 = 6'd32, F_N2 = 6'd33, F_N3 = 6'd34, F_N4 = 6'd35;
	localparam logic [5:0] F_X1 = 6'd36, F_X2 = 6'd37, FIN = 6'd38;

	logic [5:0]    state_q;
	logic [DW-1:0] head_q, node_q, prev_q, need_q, nxt_q, diff_q, rem_q, link_q;
	logic [DW-1:0] a_q, np1_q, tmp_q;
	logic [SW-1:0] sz_q, sza_q, szp_q, szn_q, t_q;
	logic [CW-1:0] count_q;
	logic          head_valid_q, at_head_q, pm_q;
	logic [ffa_pkg::ADDR_BITS-1:0] ua_q, res_addr_q;
	logic          res_fail_q, rsp_valid_q;
	logic [ffa_pkg::ADDR_BITS-1:0] alloc_address_q;
	logic          status_q;

	logic [DW-1:0] alu_x, alu_y, alu_res;
	logic          alu_sub, alu_borrow;
	logic          we;
	logic [DW-1:0] waddr, raddr;
	logic [SW-1:0] wdata, rdata;
	logic [DW-1:0] rdata_w;
	logic          walk_over;

	ffa_alu #(.DW(DW)) u_alu (
		.x(alu_x), .y(alu_y), .sub(alu_sub), .res(alu_res), .borrow(alu_borrow)
	);

	ffa_mem #(.ARENA_WORDS(ARENA_WORDS), .DW(DW), .SW(SW)) u_mem (
		.clk(clk), .arst_n(arst_n), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign rdata_w = DW'(rdata);
	assign walk_over = count_q >= CW'(ARENA_WORDS);
	assign req_ready = state_q == IDLE;
	assign rsp_valid = rsp_valid_q;
	assign alloc_address = alloc_address_q;
	assign status = status_q;

	always_comb begin
		alu_x = node_q;
		alu_y = DW'(1);
		alu_sub = 1'b0;
		we = 1'b0;
		waddr = '0;
		wdata = '0;
		raddr = '0;
		case (state_q)
			IDLE: alu_x = DW'(size_words);
			A_IT: raddr = node_q;
			A_SZ: raddr = alu_res;
			A_CK: begin
				alu_x = DW'(sz_q);
				alu_y = need_q;
				alu_sub = 1'b1;
			end
			A_W1: begin
				alu_y = need_q;
				we = 1'b1;
				waddr = node_q;
				wdata = (diff_q == DW'(1)) ? sz_q : SW'(need_q);
			end
			A_W2: begin
				we = 1'b1;
				waddr = rem_q;
				wdata = SW'(diff_q);
			end
			A_W3: begin
				alu_x = rem_q;
				we = 1'b1;
				waddr = alu_res;
				wdata = SW'(nxt_q);
			end
			A_LK: begin
				alu_x = prev_q;
				we = !at_head_q;
				waddr = alu_res;
				wdata = SW'(link_q);
			end
			F_0: begin
				alu_x = DW'(ua_q);
				alu_sub = 1'b1;
			end
			F_EMP: begin
				alu_x = a_q;
				we = 1'b1;
				waddr = alu_res;
			end
			F_1: raddr = a_q;
			F_2: begin
				alu_x = a_q;
				alu_y = head_q;
				alu_sub = 1'b1;
			end
			F_H1: begin
				alu_x = a_q;
				alu_y = DW'(sza_q);
			end
			F_HN: begin
				alu_x = a_q;
				we = 1'b1;
				waddr = alu_res;
				wdata = SW'(head_q);
			end
			F_H2: begin
				alu_x = head_q;
				raddr = alu_res;
			end
			F_H3: begin
				alu_x = a_q;
				we = 1'b1;
				waddr = alu_res;
				wdata = rdata;
			end
			F_H4: raddr = head_q;
			F_H5: begin
				alu_x = DW'(sza_q);
				alu_y = rdata_w;
				we = 1'b1;
				waddr = a_q;
				wdata = SW'(alu_res);
			end
			F_IT: begin
				alu_x = prev_q;
				raddr = alu_res;
			end
			F_W1: begin
				alu_x = a_q;
				alu_y = rdata_w;
				alu_sub = 1'b1;
			end
			F_T1, F_M1: raddr = prev_q;
			F_T2, F_M2: begin
				alu_x = prev_q;
				alu_y = rdata_w;
			end
			F_T3: begin
				we = 1'b1;
				if (pm_q) begin
					alu_x = DW'(szp_q);
					alu_y = DW'(sza_q);
					waddr = prev_q;
					wdata = SW'(alu_res);
				end else begin
					alu_x = a_q;
					waddr = alu_res;
				end
			end
			F_T4, F_X1: begin
				alu_x = prev_q;
				we = 1'b1;
				waddr = alu_res;
				wdata = SW'(a_q);
			end
			F_M3: begin
				alu_x = a_q;
				alu_y = DW'(sza_q);
			end
			F_B1, F_N1: raddr = nxt_q;
			F_B2: begin
				alu_x = DW'(szp_q);
				alu_y = DW'(sza_q);
			end
			F_B3, F_N2: begin
				alu_x = nxt_q;
				raddr = alu_res;
			end
			F_B4: begin
				alu_x = tmp_q;
				alu_y = DW'(szn_q);
				we = 1'b1;
				waddr = prev_q;
				wdata = SW'(alu_res);
			end
			F_B5: begin
				alu_x = prev_q;
				we = 1'b1;
				waddr = alu_res;
				wdata = t_q;
			end
			F_N3: begin
				alu_x = DW'(sza_q);
				alu_y = DW'(szn_q);
				we = 1'b1;
				waddr = a_q;
				wdata = SW'(alu_res);
			end
			F_N4: begin
				alu_x = a_q;
				we = 1'b1;
				waddr = alu_res;
				wdata = t_q;
			end
			F_X2: begin
				alu_x = a_q;
				we = 1'b1;
				waddr = alu_res;
				wdata = SW'(nxt_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			head_q <= '0;
			head_valid_q <= 1'b1;
			rsp_valid_q <= 1'b0;
			count_q <= '0;
			at_head_q <= 1'b1;
		end else begin
			if (state_q == FIN && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (req_valid) begin
						need_q <= alu_res;
						ua_q <= user_address;
						res_addr_q <= '0;
						res_fail_q <= ffa_pkg::STATUS_DONE;
						node_q <= head_q;
						at_head_q <= 1'b1;
						count_q <= '0;
						if (operation == ffa_pkg::OP_FREE) begin
							state_q <= F_0;
						end else if (!head_valid_q) begin
							res_fail_q <= ffa_pkg::STATUS_FAIL;
							state_q <= FIN;
						end else begin
							state_q <= A_IT;
						end
					end
				end
				A_IT: begin
					if (walk_over) begin
						res_fail_q <= ffa_pkg::STATUS_FAIL;
						state_q <= FIN;
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= A_SZ;
					end
				end
				A_SZ: begin
					sz_q <= rdata;
					np1_q <= alu_res;
					state_q <= A_CK;
				end
				A_CK: begin
					nxt_q <= rdata_w;
					diff_q <= alu_res;
					if (!alu_borrow) begin
						state_q <= A_W1;
					end else if (rdata_w == '0) begin
						res_fail_q <= ffa_pkg::STATUS_FAIL;
						state_q <= FIN;
					end else begin
						prev_q <= node_q;
						node_q <= rdata_w;
						at_head_q <= 1'b0;
						state_q <= A_IT;
					end
				end
				A_W1: begin
					rem_q <= alu_res;
					if (diff_q >= DW'(ffa_pkg::MIN_REMAINDER_WORDS)) begin
						link_q <= alu_res;
					end else begin
						link_q <= nxt_q;
					end
					state_q <= (diff_q == '0) ? A_LK : A_W2;
				end
				A_W2: begin
					if (diff_q >= DW'(ffa_pkg::MIN_REMAINDER_WORDS)) begin
						state_q <= A_W3;
					end else begin
						state_q <= A_LK;
					end
				end
				A_W3: state_q <= A_LK;
				A_LK: begin
					if (at_head_q) begin
						if (link_q == '0) begin
							head_valid_q <= 1'b0;
						end else begin
							head_q <= link_q;
						end
					end
					res_addr_q <= np1_q[ffa_pkg::ADDR_BITS-1:0];
					state_q <= FIN;
				end
				F_0: begin
					a_q <= alu_res;
					if (ua_q == '0) begin
						state_q <= FIN;
					end else if (!head_valid_q) begin
						state_q <= F_EMP;
					end else begin
						state_q <= F_1;
					end
				end
				F_EMP: begin
					head_q <= a_q;
					head_valid_q <= 1'b1;
					state_q <= FIN;
				end
				F_1: state_q <= F_2;
				F_2: begin
					sza_q <= rdata;
					if (alu_borrow) begin
						state_q <= F_H1;
					end else begin
						prev_q <= head_q;
						count_q <= '0;
						state_q <= F_IT;
					end
				end
				F_H1: state_q <= (alu_res == head_q) ? F_H2 : F_HN;
				F_HN: begin
					head_q <= a_q;
					state_q <= FIN;
				end
				F_H2: state_q <= F_H3;
				F_H3: state_q <= F_H4;
				F_H4: state_q <= F_H5;
				F_H5: begin
					head_q <= a_q;
					state_q <= FIN;
				end
				F_IT: begin
					if (walk_over) begin
						state_q <= FIN;
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= F_W1;
					end
				end
				F_W1: begin
					nxt_q <= rdata_w;
					if (rdata_w == '0) begin
						state_q <= F_T1;
					end else if (alu_borrow) begin
						state_q <= F_M1;
					end else begin
						prev_q <= rdata_w;
						state_q <= F_IT;
					end
				end
				F_T1: state_q <= F_T2;
				F_T2: begin
					szp_q <= rdata;
					pm_q <= alu_res == a_q;
					state_q <= F_T3;
				end
				F_T3: state_q <= pm_q ? FIN : F_T4;
				F_T4: state_q <= FIN;
				F_M1: state_q <= F_M2;
				F_M2: begin
					szp_q <= rdata;
					pm_q <= alu_res == a_q;
					state_q <= F_M3;
				end
				F_M3: begin
					if (pm_q && alu_res == nxt_q) begin
						state_q <= F_B1;
					end else if (pm_q) begin
						state_q <= F_T3;
					end else if (alu_res == nxt_q) begin
						state_q <= F_N1;
					end else begin
						state_q <= F_X1;
					end
				end
				F_B1: state_q <= F_B2;
				F_B2: begin
					szn_q <= rdata;
					tmp_q <= alu_res;
					state_q <= F_B3;
				end
				F_B3: state_q <= F_B4;
				F_B4: begin
					t_q <= rdata;
					state_q <= F_B5;
				end
				F_B5: state_q <= FIN;
				F_N1: state_q <= F_N2;
				F_N2: begin
					szn_q <= rdata;
					state_q <= F_N3;
				end
				F_N3: begin
					t_q <= rdata;
					state_q <= F_N4;
				end
				F_N4: state_q <= F_T4;
				F_X1: state_q <= F_X2;
				F_X2: state_q <= FIN;
				FIN: begin
					if (!rsp_valid_q || rsp_ready) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FIN && (!rsp_valid_q || rsp_ready)) begin
			alloc_address_q <= res_addr_q;
			status_q <= res_fail_q;
		end
	end
endmodule

/* tb/sv/first_fit_free_list_allocator_tb.sv */
// testbench for the first-fit free-list allocator: alloc/free traffic checked against a predictor
module first_fit_free_list_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ARENA = ffa_pkg::ARENA_WORDS_DEF;
	localparam int RANDOM_ITEMS = 1030;
	localparam int QUIET_AFTER = 900;
	localparam int HOLD_AT = 300;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic                          op;
		logic [ffa_pkg::SIZE_BITS-1:0] size;
		logic [ffa_pkg::ADDR_BITS-1:0] addr;
		logic [ffa_pkg::ADDR_BITS-1:0] exp_addr;
		logic                          exp_status;
	} request_t;

	logic clk;
	logic arst_n;
	logic req_valid, req_ready, operation, rsp_valid, rsp_ready, status;
	logic [ffa_pkg::SIZE_BITS-1:0] size_words;
	logic [ffa_pkg::ADDR_BITS-1:0] user_address, alloc_address;

	request_t pending_requests[$];
	request_t inflight_grants[$];
	request_t current;
	int total_requests, accepted, checked, errors;
	int n_allocs, n_frees, n_fails;
	bit stimulus_done;

	// allocator shadow
	int unsigned hdr[ARENA];
	int unsigned head;
	bit head_ok;
	logic [ffa_pkg::ADDR_BITS-1:0] live[$];

	first_fit_free_list_allocator i_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .operation(operation),
		.size_words(size_words), .user_address(user_address),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
		.alloc_address(alloc_address), .status(status)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int unsigned rd(int unsigned i);
		return (i < ARENA) ? hdr[i] : 0;
	endfunction

	function automatic void wr(int unsigned i, int unsigned v);
		if (i < ARENA) hdr[i] = v;
	endfunction

	function automatic void relink(bit at_head, int unsigned prev, int unsigned v);
		if (at_head) begin
			if (v == 0) head_ok = 0;
			else head = v;
		end else wr(prev + 1, v);
	endfunction

	function automatic int unsigned carve(int unsigned size, output bit fail);
		int unsigned need, node, prev, cnt, sz, nxt, link, rem;
		bit at_head;
		need = size + 1;
		prev = 0;
		cnt = 0;
		at_head = 1;
		fail = 1;
		if (!head_ok) return 0;
		node = head;
		forever begin
			if (cnt >= ARENA) return 0;
			cnt++;
			sz = rd(node);
			nxt = rd(node + 1);
			if (sz >= need) begin
				link = nxt;
				wr(node, need);
				if (sz != need) begin
					rem = node + need;
					wr(rem, sz - need);
					if (sz - need < ffa_pkg::MIN_REMAINDER_WORDS)
						wr(node, rd(node) + (sz - need));
					else begin
						wr(rem + 1, nxt);
						link = rem;
					end
				end
				relink(at_head, prev, link);
				fail = 0;
				return node + 1;
			end
			if (nxt == 0) return 0;
			at_head = 0;
			prev = node;
			node = nxt;
		end
	endfunction

	function automatic void release_block(int unsigned ua);
		int unsigned a, sz, h, prev, cnt, nxt;
		bit pm, nm;
		cnt = 0;
		if (ua == 0) return;
		a = ua - 1;
		if (!head_ok) begin
			head = a;
			head_ok = 1;
			wr(a + 1, 0);
			return;
		end
		sz = rd(a);
		h = head;
		if (h > a) begin
			if (h == a + sz) begin
				wr(a + 1, rd(h + 1));
				wr(a, sz + rd(h));
			end else wr(a + 1, h);
			head = a;
			return;
		end
		prev = h;
		while (cnt < ARENA) begin
			nxt = rd(prev + 1);
			cnt++;
			if (nxt == 0) begin
				if (prev + rd(prev) == a) wr(prev, rd(prev) + rd(a));
				else begin
					wr(a + 1, 0);
					wr(prev + 1, a);
				end
				return;
			end
			if (nxt > a) begin
				pm = (prev + rd(prev) == a);
				nm = (a + rd(a) == nxt);
				if (pm && nm) begin
					wr(prev, rd(prev) + rd(a) + rd(nxt));
					wr(prev + 1, rd(nxt + 1));
				end else if (pm) wr(prev, rd(prev) + rd(a));
				else if (nm) begin
					wr(a, rd(a) + rd(nxt));
					wr(a + 1, rd(nxt + 1));
					wr(prev + 1, a);
				end else begin
					wr(prev + 1, a);
					wr(a + 1, nxt);
				end
				return;
			end
			prev = nxt;
		end
	endfunction

	// predicts the response and queues the request; frees only touch granted blocks
	task automatic queue_alloc(int unsigned size);
		request_t r;
		bit fail;
		int unsigned got;
		r.op = ffa_pkg::OP_ALLOC;
		r.size = ffa_pkg::SIZE_BITS'(size);
		r.addr = ffa_pkg::ADDR_BITS'($urandom);
		got = carve(size, fail);
		r.exp_addr = fail ? '0 : got[ffa_pkg::ADDR_BITS-1:0];
		r.exp_status = fail ? ffa_pkg::STATUS_FAIL : ffa_pkg::STATUS_DONE;
		if (!fail) live.push_back(got[ffa_pkg::ADDR_BITS-1:0]);
		pending_requests.push_back(r);
	endtask

	task automatic queue_free(int idx);
		request_t r;
		r.op = ffa_pkg::OP_FREE;
		r.size = ffa_pkg::SIZE_BITS'($urandom);
		if (idx < 0 || live.size() == 0) r.addr = '0;
		else begin
			r.addr = live[idx];
			live.delete(idx);
		end
		release_block(r.addr);
		r.exp_addr = '0;
		r.exp_status = ffa_pkg::STATUS_DONE;
		pending_requests.push_back(r);
	endtask

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("mismatch on transfer %0d: %s got %0h want %0h", checked, what, got, want);
		errors++;
	endtask

	// request driver
	int req_gap;
	always @(posedge clk or negedge arst_n) begin
		request_t nx;
		bit take;
		if (!arst_n) begin
			req_valid <= 1'b0;
			operation <= ffa_pkg::OP_ALLOC;
			size_words <= '0;
			user_address <= '0;
			req_gap = 0;
		end else begin
			take = !req_valid;
			if (req_valid && req_ready) begin
				inflight_grants.push_back(current);
				accepted++;
				take = 1;
				if (accepted < QUIET_AFTER && $urandom_range(0, 5) == 0)
					req_gap = $urandom_range(1, 7);
			end
			if (take) begin
				if (req_gap > 0) begin
					req_gap--;
					req_valid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					nx = pending_requests.pop_front();
					current = nx;
					req_valid <= 1'b1;
					operation <= nx.op;
					size_words <= nx.size;
					user_address <= nx.addr;
				end else req_valid <= 1'b0;
			end
		end
	end

	// response monitor with stalls and one long hold-off
	int rsp_gap, hold_left;
	bit hold_done;
	always @(posedge clk or negedge arst_n) begin
		request_t e;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			rsp_gap = 0;
			hold_left = 0;
			hold_done = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (inflight_grants.size() == 0) begin
					report_mismatch("transfers outstanding", 0, 1);
				end else begin
					e = inflight_grants.pop_front();
					if (alloc_address !== e.exp_addr)
						report_mismatch("alloc_address", alloc_address, e.exp_addr);
					if (status !== e.exp_status)
						report_mismatch("status", status, e.exp_status);
					if (e.op == ffa_pkg::OP_ALLOC) begin
						n_allocs++;
						if (e.exp_status == ffa_pkg::STATUS_FAIL) n_fails++;
					end else n_frees++;
				end
				checked++;
			end
			if (!hold_done && accepted >= HOLD_AT) begin
				hold_done = 1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else if (rsp_gap > 0) begin
				rsp_gap--;
				rsp_ready <= 1'b0;
			end else if (accepted < QUIET_AFTER && $urandom_range(0, 5) == 0) begin
				rsp_gap = $urandom_range(0, 6);
				rsp_ready <= 1'b0;
			end else rsp_ready <= 1'b1;
		end
	end

	initial begin
		int k;
		for (int i = 0; i < ARENA; i++) hdr[i] = 0;
		hdr[0] = ARENA;
		head = 0;
		head_ok = 1;
		// directed: edges, empty list, every merge shape
		queue_alloc(4094);
		queue_alloc(0);
		queue_free(-1);
		queue_free(0);
		queue_alloc(5);
		queue_alloc(3);
		queue_alloc(7);
		queue_alloc(2);
		queue_free(1);
		queue_free(2);
		queue_free(1);
		queue_alloc(4);
		queue_alloc(4000);
		queue_alloc(4094);
		queue_free(live.size() - 1);
		while (live.size() > 0) queue_free(0);
		queue_alloc(4094);
		queue_free(0);
		queue_alloc(4095 - 2048);
		queue_alloc(2047);
		queue_alloc(1);
		queue_free(0);
		queue_free(0);
		// random: mostly small blocks, some large, a few null frees
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			k = $urandom_range(0, 99);
			if (k < 3) queue_free(-1);
			else if (k < 55 || live.size() == 0) begin
				if ($urandom_range(0, 19) == 0) queue_alloc($urandom_range(1, 4094));
				else queue_alloc($urandom_range(1, 40));
			end else queue_free($urandom_range(0, live.size() - 1));
		end
		total_requests = pending_requests.size();
		stimulus_done = 1;
	end

	initial begin
		errors = 0;
		accepted = 0;
		checked = 0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		wait (stimulus_done && accepted == total_requests && inflight_grants.size() == 0);
		repeat (100) @(posedge clk);
		$display("covered %0d requests: %0d allocs (%0d refused), %0d frees",
			checked, n_allocs, n_fails, n_frees);
		if (errors == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end

	initial begin
		#20ms;
		$display("timeout after %0d responses", checked);
		$display("Test completed with failures");
		$finish;
	end
endmodule

/* filelist.f */
rtl/ffa_pkg.sv
rtl/ffa_alu.sv
rtl/ffa_mem.sv
rtl/first_fit_free_list_allocator.sv
tb/sv/first_fit_free_list_allocator_tb.sv
